// ----- design/vsf_pkg.sv -----
// Shared types, constants and register codes for the VGA scan line fetch block.
// No dependencies; every other file imports this package.
package vsf_pkg;

  localparam int CFG_W     = 11;   // width of every timing register
  localparam int POS_W     = 13;   // column and row counters
  localparam int FETCH_W   = 20;   // frame-buffer address on the result channel
  localparam int STRIDE_W  = 12;   // h_visible plus border
  localparam int BUF_W     = 23;   // stride times visible rows
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam int LINE_REPEAT_DEF   = 2;
  localparam int BORDER_PIXELS_DEF = 4;
  localparam int ADDR_BITS_DEF     = 20;

  localparam logic [CFG_W-1:0] H_BACK_RST    = 11'd44;
  localparam logic [CFG_W-1:0] H_VISIBLE_RST = 11'd400;
  localparam logic [CFG_W-1:0] H_FRONT_RST   = 11'd20;
  localparam logic [CFG_W-1:0] H_SYNC_RST    = 11'd64;
  localparam logic [CFG_W-1:0] V_BACK_RST    = 11'd11;
  localparam logic [CFG_W-1:0] V_VISIBLE_RST = 11'd300;
  localparam logic [CFG_W-1:0] V_FRONT_RST   = 11'd1;
  localparam logic [CFG_W-1:0] V_SYNC_RST    = 11'd2;

  typedef enum logic [2:0] {
    REG_H_BACK    = 3'd0,
    REG_H_VISIBLE = 3'd1,
    REG_H_FRONT   = 3'd2,
    REG_H_SYNC    = 3'd3,
    REG_V_BACK    = 3'd4,
    REG_V_VISIBLE = 3'd5,
    REG_V_FRONT   = 3'd6,
    REG_V_SYNC    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] h_back;
    logic [CFG_W-1:0] h_visible;
    logic [CFG_W-1:0] h_front;
    logic [CFG_W-1:0] h_sync;
    logic [CFG_W-1:0] v_back;
    logic [CFG_W-1:0] v_visible;
    logic [CFG_W-1:0] v_front;
    logic [CFG_W-1:0] v_sync;
    logic [BUF_W-1:0] buf_end;
  } cfg_t;

  typedef struct packed {
    logic               hsync_level;
    logic               vsync_level;
    logic               pixel_active;
    logic [FETCH_W-1:0] fetch_address;
    logic               line_end;
    logic               frame_start;
  } res_t;

endpackage

// ----- design/vsf_if.sv -----
// Handshake channels of the scan block: tick words in, timing/fetch words out.
// Depends on vsf_pkg for the address width.
interface vsf_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface vsf_out_if import vsf_pkg::*;;
  logic               valid;
  logic               ready;
  logic               hsync_level;
  logic               vsync_level;
  logic               pixel_active;
  logic [FETCH_W-1:0] fetch_address;
  logic               line_end;
  logic               frame_start;

  modport source (output valid, output hsync_level, output vsync_level, output pixel_active,
                  output fetch_address, output line_end, output frame_start, input ready);
  modport sink (input valid, input hsync_level, input vsync_level, input pixel_active,
                input fetch_address, input line_end, input frame_start, output ready);
endinterface

// ----- design/vga_scan_line_fetch.sv -----
// VGA scan timing generator with frame-buffer line fetch. Each input word is one
// pixel-clock tick; the result word reports sync levels, the visible-pixel flag and
// the fetch address for the position before the tick, then the position advances.
// One word is accepted every cycle unless the result side stalls; each word passes
// through the input register and then the result register, and the input register
// can hold the next word while a finished word waits. Timing registers are written
// through APB at 4*index and should only change while no words are in flight.
module vga_scan_line_fetch import vsf_pkg::*; #(
  parameter int LINE_REPEAT   = LINE_REPEAT_DEF,
  parameter int BORDER_PIXELS = BORDER_PIXELS_DEF,
  parameter int ADDR_BITS     = ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  vsf_in_if.sink             pix_in,
  vsf_out_if.source          pix_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic s1_valid;
  logic s1_tick;
  logic out_valid;
  logic s1_go;

  vsf_regs #(
    .BORDER_PIXELS(BORDER_PIXELS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vsf_scan #(
    .LINE_REPEAT   (LINE_REPEAT),
    .BORDER_PIXELS (BORDER_PIXELS),
    .ADDR_BITS     (ADDR_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (s1_go),
    .tick (s1_tick),
    .res  (res)
  );

  // advance the held word whenever the result slot is free or draining
  assign s1_go        = s1_valid && (!out_valid || pix_out.ready);
  assign pix_in.ready = !rst && (!s1_valid || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pix_in.ready) begin
        s1_valid <= pix_in.valid;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.valid && pix_in.ready) begin
      s1_tick <= pix_in.tick;
    end
    if (s1_go) begin
      res_q <= res;
    end
  end

  assign pix_out.valid         = out_valid;
  assign pix_out.hsync_level   = res_q.hsync_level;
  assign pix_out.vsync_level   = res_q.vsync_level;
  assign pix_out.pixel_active  = res_q.pixel_active;
  assign pix_out.fetch_address = res_q.fetch_address;
  assign pix_out.line_end      = res_q.line_end;
  assign pix_out.frame_start   = res_q.frame_start;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pix_out.ready) |=> out_valid && $stable(res_q))
    else $error("result word changed while stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !pix_out.ready) |-> !pix_in.ready)
    else $error("input taken while both stages are full");

  a_go_fills: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_valid)
    else $error("advanced word did not reach the result register");

endmodule

// ----- design/vsf_regs.sv -----
// APB register file for the line and frame timing, plus the frame-buffer size.
// Depends on vsf_pkg.
module vsf_regs import vsf_pkg::*; #(
  parameter int BORDER_PIXELS = BORDER_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  localparam logic [STRIDE_W-1:0] BORDER = STRIDE_W'(BORDER_PIXELS);
  localparam logic [BUF_W-1:0] BUF_END_RST =
    BUF_W'((int'(H_VISIBLE_RST) + BORDER_PIXELS) * int'(V_VISIBLE_RST));

  reg_idx_t         idx;
  logic             wr;
  logic [CFG_W-1:0] wval;
  logic [CFG_W-1:0] rval;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign wval   = pwdata[CFG_W-1:0];
  assign pready = 1'b1;
  assign prdata = PDATA_W'(rval);

  always_comb begin
    unique case (idx)
      REG_H_BACK:    rval = cfg.h_back;
      REG_H_VISIBLE: rval = cfg.h_visible;
      REG_H_FRONT:   rval = cfg.h_front;
      REG_H_SYNC:    rval = cfg.h_sync;
      REG_V_BACK:    rval = cfg.v_back;
      REG_V_VISIBLE: rval = cfg.v_visible;
      REG_V_FRONT:   rval = cfg.v_front;
      REG_V_SYNC:    rval = cfg.v_sync;
      default:       rval = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.h_back    <= H_BACK_RST;
      cfg.h_visible <= H_VISIBLE_RST;
      cfg.h_front   <= H_FRONT_RST;
      cfg.h_sync    <= H_SYNC_RST;
      cfg.v_back    <= V_BACK_RST;
      cfg.v_visible <= V_VISIBLE_RST;
      cfg.v_front   <= V_FRONT_RST;
      cfg.v_sync    <= V_SYNC_RST;
      cfg.buf_end   <= BUF_END_RST;
    end else if (wr) begin
      unique case (idx)
        REG_H_BACK: cfg.h_back <= wval;
        REG_H_VISIBLE: begin
          cfg.h_visible <= wval;
          // buffer size follows the new stride
          cfg.buf_end <= BUF_W'({1'b0, wval} + BORDER) * BUF_W'(cfg.v_visible);
        end
        REG_H_FRONT: cfg.h_front <= wval;
        REG_H_SYNC:  cfg.h_sync <= wval;
        REG_V_BACK:  cfg.v_back <= wval;
        REG_V_VISIBLE: begin
          cfg.v_visible <= wval;
          cfg.buf_end <= BUF_W'({1'b0, cfg.h_visible} + BORDER) * BUF_W'(wval);
        end
        REG_V_FRONT: cfg.v_front <= wval;
        REG_V_SYNC:  cfg.v_sync <= wval;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/vsf_scan.sv -----
// Position counters, sync decode and frame-buffer address for one pixel clock.
// Depends on vsf_pkg; configuration comes from vsf_regs.
module vsf_scan import vsf_pkg::*; #(
  parameter int LINE_REPEAT   = LINE_REPEAT_DEF,
  parameter int BORDER_PIXELS = BORDER_PIXELS_DEF,
  parameter int ADDR_BITS     = ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic step,
  input  logic tick,
  output res_t res
);

  localparam int REP_W = (LINE_REPEAT > 1) ? $clog2(LINE_REPEAT) : 1;
  localparam int LB_W  = ADDR_BITS + 1;
  localparam int AD_W  = ADDR_BITS + 2;
  localparam int CMP_W = (AD_W > BUF_W) ? AD_W : BUF_W;
  localparam logic [LB_W-1:0] LB_LIMIT = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [REP_W:0]  REP_LAST = (REP_W + 1)'(LINE_REPEAT);

  logic [POS_W-1:0] column_count, column_count_next;
  logic [POS_W-1:0] row_count, row_count_next;
  logic [REP_W-1:0] repeat_count, repeat_count_next;
  logic [LB_W-1:0]  line_base, line_base_next;
  logic             in_blanking, in_blanking_next;

  logic [POS_W-1:0]    line_total, frame_total;
  logic [CFG_W:0]      h_vis_end, v_vis_end;
  logic [STRIDE_W-1:0] stride;
  logic                h_vis, shown, last_pix, first_pix, rep_last;
  logic [POS_W-1:0]    offset;
  logic [AD_W-1:0]     addr;
  logic                active;
  logic [POS_W:0]      col_inc, row_inc;
  logic [POS_W-1:0]    col_n, row_n;
  logic                row_go, blank_n;
  logic [LB_W-1:0]     lb_sum;

  assign line_total  = POS_W'(cfg.h_back) + POS_W'(cfg.h_visible)
                     + POS_W'(cfg.h_front) + POS_W'(cfg.h_sync);
  assign frame_total = POS_W'(cfg.v_back) + POS_W'(cfg.v_visible)
                     + POS_W'(cfg.v_front) + POS_W'(cfg.v_sync);
  assign h_vis_end   = {1'b0, cfg.h_back} + {1'b0, cfg.h_visible};
  assign v_vis_end   = {1'b0, cfg.v_back} + {1'b0, cfg.v_visible};
  assign stride      = {1'b0, cfg.h_visible} + STRIDE_W'(BORDER_PIXELS);

  // decode of the current position
  assign h_vis = (cfg.h_visible != '0) && (column_count >= POS_W'(cfg.h_back))
              && (column_count < POS_W'(h_vis_end));
  assign shown    = h_vis && !in_blanking;
  assign last_pix = shown && (column_count == POS_W'(h_vis_end) - POS_W'(1));
  assign first_pix = shown && (column_count == POS_W'(cfg.h_back))
                  && (row_count == POS_W'(cfg.v_back)) && (repeat_count == '0);
  assign rep_last = ({1'b0, repeat_count} + (REP_W + 1)'(1)) >= REP_LAST;

  assign offset = column_count - POS_W'(cfg.h_back);
  assign addr   = AD_W'(line_base) + AD_W'(offset[CFG_W-1:0]);
  assign active = shown && (CMP_W'(addr) < CMP_W'(cfg.buf_end))
               && (addr[AD_W-1:ADDR_BITS] == '0);

  always_comb begin
    res.hsync_level   = !((cfg.h_sync != '0) &&
                          (({1'b0, column_count} + (POS_W + 1)'(cfg.h_sync))
                           >= (POS_W + 1)'(line_total)));
    res.vsync_level   = !((cfg.v_sync != '0) &&
                          (({1'b0, row_count} + (POS_W + 1)'(cfg.v_sync))
                           >= (POS_W + 1)'(frame_total)));
    res.pixel_active  = active;
    res.fetch_address = active ? FETCH_W'(addr) : '0;
    res.line_end      = last_pix;
    res.frame_start   = first_pix;
  end

  // advance of the position
  assign col_inc = {1'b0, column_count} + (POS_W + 1)'(1);
  assign col_n   = (col_inc >= (POS_W + 1)'(line_total)) ? '0 : col_inc[POS_W-1:0];
  assign row_inc = {1'b0, row_count} + (POS_W + 1)'(1);
  assign row_n   = (row_inc >= (POS_W + 1)'(frame_total)) ? '0 : row_inc[POS_W-1:0];
  assign row_go  = (col_n == POS_W'(cfg.h_back)) && rep_last;
  assign blank_n = !((cfg.v_visible != '0) && (row_n >= POS_W'(cfg.v_back))
                     && (row_n < POS_W'(v_vis_end)));
  assign lb_sum  = line_base + LB_W'(stride);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    repeat_count_next = repeat_count;
    line_base_next    = line_base;
    in_blanking_next  = in_blanking;
    if (step && tick) begin
      if (last_pix && rep_last) begin
        line_base_next = (lb_sum > LB_LIMIT) ? LB_LIMIT : lb_sum;
      end
      column_count_next = col_n;
      if (col_n == POS_W'(cfg.h_back)) begin
        if (rep_last) begin
          repeat_count_next = '0;
          row_count_next    = row_n;
          in_blanking_next  = blank_n;
        end else begin
          repeat_count_next = repeat_count + REP_W'(1);
        end
      end
      if (row_go ? blank_n : in_blanking) begin
        line_base_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      repeat_count <= '0;
      line_base    <= '0;
      in_blanking  <= 1'b1;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      repeat_count <= repeat_count_next;
      line_base    <= line_base_next;
      in_blanking  <= in_blanking_next;
    end
  end

  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, repeat_count} < REP_LAST)
    else $error("repeat count out of range");

  a_blank_base: assert property (@(posedge clk) disable iff (rst)
    in_blanking |-> (line_base == '0))
    else $error("line base not cleared in vertical blanking");

  a_base_limit: assert property (@(posedge clk) disable iff (rst)
    line_base <= LB_LIMIT)
    else $error("line base past address limit");

  a_column_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !(step && tick)) |=> $stable(column_count) && $stable(row_count))
    else $error("position moved without a tick");

endmodule
